// ----- hw/rtl/c3vw_pkg.sv -----
// ----------------------------------------------------------------------------
// c3vw_pkg: shared types and constants of the 3x3 valid-window convolver
// Field widths, configuration register indexes and the default line length.
// ----------------------------------------------------------------------------
package c3vw_pkg;

    localparam int PIXEL_W       = 8;
    localparam int COEF_W        = 16;
    localparam int KSIZE         = 3;
    localparam int KROW_W        = KSIZE * COEF_W;
    localparam int SIZE_W        = 11;
    localparam int VALUE_W       = 28;
    localparam int PROD_W        = PIXEL_W + 1 + COEF_W;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int SIZE_RESET    = 1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = KROW_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KROW0 = 2'd0,
        CFG_KROW1 = 2'd1,
        CFG_KROW2 = 2'd2,
        CFG_SIZE  = 2'd3
    } t_cfg_idx;

endpackage

// ----- hw/rtl/c3vw_pix_if.sv -----
// ----------------------------------------------------------------------------
// c3vw_pix_if: pixel stream channel
// Valid/ready channel that carries one unsigned pixel per item.
// ----------------------------------------------------------------------------
interface c3vw_pix_if;
    import c3vw_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// ----- hw/rtl/c3vw_res_if.sv -----
// ----------------------------------------------------------------------------
// c3vw_res_if: convolution result channel
// Valid/ready channel that carries one window sum and an end-of-frame flag.
// ----------------------------------------------------------------------------
interface c3vw_res_if;
    import c3vw_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] conv_value;
    logic                      last_of_frame;

    modport source (output valid, output conv_value, output last_of_frame, input ready);
    modport sink   (input valid, input conv_value, input last_of_frame, output ready);
endinterface

// ----- hw/rtl/conv3x3_valid_window.sv -----
// ----------------------------------------------------------------------------
// conv3x3_valid_window: streaming 3x3 correlation over the valid region
// Line-buffered 3x3 window with nine multipliers and an adder tree.
// ----------------------------------------------------------------------------
// Pixels of an n x n image enter in raster order, one item per clock when the
// result side keeps up; from the third row and third column on, each pixel
// yields one signed 28-bit result, the window sum of pixel times coefficient
// (kernel not flipped), and the last result of the frame carries
// last_of_frame. In the pipeline, stage 1 takes the pixel on the edge that
// accepts it and also reads the line stores, stage 2 registers the nine
// products and stage 3 registers the adder-tree sum. Throughput is one
// item per clock when the result side keeps up, set by the single read and
// single write port of each line store, which are used once per pixel. Each
// stage holds its item only while the stage after it is full and stalled, so
// the input keeps taking items into empty stages while a result waits. Write
// configuration only while the block is idle. Writing image_size restarts the
// frame at the next pixel; values outside 3..MAX_WIDTH are clamped. Kernel
// rows hold three signed 16-bit coefficients, left one in bits 15:0.
// ----------------------------------------------------------------------------
module conv3x3_valid_window #(
    parameter int MAX_WIDTH = c3vw_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [c3vw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [c3vw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    c3vw_pix_if.sink                        i_pix,
    c3vw_res_if.source                      o_res
);
    import c3vw_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int NW = $clog2(MAX_WIDTH + 1);
    localparam int SW = (SIZE_W > NW) ? SIZE_W : NW;

    // configuration
    logic [KROW_W-1:0] r_krow [KSIZE];
    logic [SIZE_W-1:0] r_image_size;

    // position of the next pixel
    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;

    // stage 1: pixel and line-store read
    logic               r1_valid;
    logic [PIXEL_W-1:0] r1_pixel;
    logic [CW-1:0]      r1_col;
    logic               r1_produce;
    logic               r1_last;

    // stage 2: products
    logic                     r2_valid;
    logic signed [PROD_W-1:0] r2_prod [KSIZE*KSIZE];
    logic                     r2_last;

    // stage 3: result register
    logic                      r3_valid;
    logic signed [VALUE_W-1:0] r3_value;
    logic                      r3_last;

    // window: [row][0] is column c-2, [row][1] is column c-1
    logic [PIXEL_W-1:0] r_win [KSIZE][KSIZE-1];

    logic [PIXEL_W-1:0] upper_rd, lower_rd;
    logic [PIXEL_W-1:0] cur [KSIZE];
    logic signed [PROD_W-1:0] prod [KSIZE*KSIZE];
    logic signed [VALUE_W-1:0] sum;

    logic en1, en2, en3;
    logic accept, line_we, size_we;
    logic [SW-1:0] size_ext, n_eff, col_ext, row_ext;
    logic col_end, row_end, produce, last;

    // stage enables: a stage loads when it is empty or its item moves on
    assign en3     = !r3_valid || o_res.ready;
    assign en2     = !r2_valid || en3;
    assign en1     = !r1_valid || en2;
    assign accept  = i_pix.valid && en1;
    assign line_we = r1_valid && en2;
    assign size_we = i_cfg_we && (i_cfg_index == CFG_SIZE);

    assign i_pix.ready = en1;

    // clamp the side length to 3..MAX_WIDTH
    always_comb begin
        size_ext = SW'(r_image_size);
        if (size_ext < SW'(KSIZE)) begin
            n_eff = SW'(KSIZE);
        end else if (size_ext > SW'(MAX_WIDTH)) begin
            n_eff = SW'(MAX_WIDTH);
        end else begin
            n_eff = size_ext;
        end
    end

    assign col_ext = SW'(r_col);
    assign row_ext = SW'(r_row);
    assign col_end = (col_ext + SW'(1)) >= n_eff;
    assign row_end = (row_ext + SW'(1)) >= n_eff;
    assign produce = (r_row >= CW'(KSIZE - 1)) && (r_col >= CW'(KSIZE - 1));
    assign last    = (row_ext == n_eff - SW'(1)) && (col_ext == n_eff - SW'(1));

    // advance the raster position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_end) begin
            n_col = '0;
            n_row = row_end ? '0 : r_row + CW'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    // configuration registers and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < KSIZE; r++) begin
                r_krow[r] <= '0;
            end
            r_image_size <= SIZE_W'(SIZE_RESET);
            r_col        <= '0;
            r_row        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_KROW0: r_krow[0]    <= i_cfg_data[KROW_W-1:0];
                    CFG_KROW1: r_krow[1]    <= i_cfg_data[KROW_W-1:0];
                    CFG_KROW2: r_krow[2]    <= i_cfg_data[KROW_W-1:0];
                    CFG_SIZE:  r_image_size <= i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            // restart the frame on a size write
            if (size_we) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // line stores: read the column of the incoming pixel, write back when
    // the item leaves stage 1 (upper takes the old lower row)
    c3vw_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (r1_col),
        .i_wdata (lower_rd),
        .i_re    (en1),
        .i_raddr (r_col),
        .o_rdata (upper_rd)
    );

    c3vw_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_lower (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (r1_col),
        .i_wdata (r1_pixel),
        .i_re    (en1),
        .i_raddr (r_col),
        .o_rdata (lower_rd)
    );

    // stage 1 control and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_pixel   <= i_pix.pixel;
            r1_col     <= r_col;
            r1_produce <= produce;
            r1_last    <= last;
        end
    end

    // current column of the window: rows r-2, r-1 and the new pixel
    assign cur[0] = upper_rd;
    assign cur[1] = lower_rd;
    assign cur[2] = r1_pixel;

    // nine independent products, pixel zero-extended, coefficient signed
    always_comb begin
        logic [PIXEL_W-1:0] px [KSIZE];
        logic signed [COEF_W-1:0] cf;
        for (int r = 0; r < KSIZE; r++) begin
            for (int k = 0; k < KSIZE - 1; k++) begin
                px[k] = r_win[r][k];
            end
            px[KSIZE-1] = cur[r];
            for (int k = 0; k < KSIZE; k++) begin
                cf = $signed(r_krow[r][COEF_W*k +: COEF_W]);
                prod[r*KSIZE + k] = $signed({1'b0, px[k]}) * cf;
            end
        end
    end

    // shift the window as the item leaves stage 1
    always_ff @(posedge i_clk) begin
        if (line_we) begin
            for (int r = 0; r < KSIZE; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= cur[r];
            end
        end
    end

    // stage 2: drop items outside the valid region here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid && r1_produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            for (int i = 0; i < KSIZE*KSIZE; i++) begin
                r2_prod[i] <= prod[i];
            end
            r2_last <= r1_last;
        end
    end

    // adder tree, wraps to the result width
    always_comb begin
        sum = '0;
        for (int i = 0; i < KSIZE*KSIZE; i++) begin
            sum = sum + VALUE_W'(r2_prod[i]);
        end
    end

    // stage 3: result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_value <= sum;
            r3_last  <= r2_last;
        end
    end

    assign o_res.valid         = r3_valid;
    assign o_res.conv_value    = r3_value;
    assign o_res.last_of_frame = r3_last;

    // position always lies inside the clamped image
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (col_ext < n_eff) && (row_ext < n_eff))
        else $error("raster position outside the image");

    // a line-store write never hits the column being read
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (line_we && en1) |-> (r1_col != r_col))
        else $error("line store read and write at the same column");

    // an empty first stage always takes an item
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r1_valid |-> i_pix.ready)
        else $error("input stalled with an empty first stage");
endmodule

// ----- hw/rtl/c3vw_ram.sv -----
// ----------------------------------------------------------------------------
// c3vw_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module c3vw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
